>>> hdl/b64d_pkg.sv
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [1:0] LAST_POS   = 2'd3;

  // one decoded group, or one error marker, on its way to the serializer
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       fin;
    logic       err;
  } rec_t;

endpackage

>>> hdl/b64d_front.sv
module b64d_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] char_code
  input  logic           in_tlast,   // end_of_text
  input  logic           q_full,
  output logic           push,
  output b64d_pkg::rec_t push_rec
);
  import b64d_pkg::*;

  logic [5:0] sext_r [3];
  logic [5:0] sext_nxt [3];
  logic [5:0] s_upd [3];
  logic [1:0] pos_r, pos_nxt;
  logic [2:0] pad_r, pad_nxt, pad_new;
  logic       fail_r, fail_nxt;
  logic       accept;
  logic [5:0] val, last;
  logic       is_pad, is_bad;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    val    = 6'd0;
    is_pad = 1'b0;
    is_bad = 1'b0;
    if (in_tdata >= 8'h41 && in_tdata <= 8'h5A) begin
      val = 6'(in_tdata - 8'h41);
    end else if (in_tdata >= 8'h61 && in_tdata <= 8'h7A) begin
      val = 6'(in_tdata - 8'h47);
    end else if (in_tdata >= 8'h30 && in_tdata <= 8'h39) begin
      val = 6'(in_tdata + 8'd4);
    end else if (in_tdata == PLUS_CHAR) begin
      val = 6'd62;
    end else if (in_tdata == SLASH_CHAR) begin
      val = 6'd63;
    end else if (in_tdata == PAD_CHAR) begin
      is_pad = 1'b1;
    end else begin
      is_bad = 1'b1;
    end
  end

  always_comb begin
    pad_new = (is_pad && pad_r != 3'd7) ? pad_r + 3'd1 : pad_r;
    s_upd   = sext_r;
    if (pos_r != LAST_POS) s_upd[pos_r] = val;
    last = (pos_r == LAST_POS) ? val : 6'd0;

    push_rec.b0  = {s_upd[0], s_upd[1][5:4]};
    push_rec.b1  = {s_upd[1][3:0], s_upd[2][5:2]};
    push_rec.b2  = {s_upd[2][1:0], last};
    push_rec.cnt = (pad_new >= 3'd2) ? 2'd1 : (pad_new == 3'd1) ? 2'd2 : 2'd3;
    push_rec.fin = 1'b0;
    push_rec.err = 1'b0;

    push     = 1'b0;
    sext_nxt = sext_r;
    pos_nxt  = pos_r;
    pad_nxt  = pad_r;
    fail_nxt = fail_r;

    if (accept) begin
      if (!fail_r) begin
        if (is_bad) begin
          fail_nxt = 1'b1;
        end else if (pos_r == LAST_POS) begin
          push         = 1'b1;
          push_rec.fin = in_tlast;
          sext_nxt     = '{default: 6'd0};
          pos_nxt      = 2'd0;
          pad_nxt      = 3'd0;
        end else begin
          sext_nxt = s_upd;
          pos_nxt  = pos_r + 2'd1;
          pad_nxt  = pad_new;
          if (in_tlast) begin
            if (pad_new == 3'd0) begin
              fail_nxt = 1'b1;
            end else begin
              push         = 1'b1;
              push_rec.fin = 1'b1;
            end
          end
        end
      end
      if (in_tlast) begin
        if (fail_nxt) begin
          push         = 1'b1;
          push_rec.b0  = 8'd0;
          push_rec.cnt = 2'd1;
          push_rec.fin = 1'b1;
          push_rec.err = 1'b1;
        end
        sext_nxt = '{default: 6'd0};
        pos_nxt  = 2'd0;
        pad_nxt  = 3'd0;
        fail_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sext_r <= '{default: 6'd0};
      pos_r  <= 2'd0;
      pad_r  <= 3'd0;
      fail_r <= 1'b0;
    end else begin
      sext_r <= sext_nxt;
      pos_r  <= pos_nxt;
      pad_r  <= pad_nxt;
      fail_r <= fail_nxt;
    end
  end

endmodule

>>> hdl/b64d_queue.sv
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::rec_t push_rec,
  input  logic           pop,
  output b64d_pkg::rec_t head,
  output logic           not_empty,
  output logic           full
);
  import b64d_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rec_t          slot_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == FULL_CNT);
  assign head      = slot_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == LAST_IDX) ? '0 : wp_r + AW'(1);
    if (do_pop)  rp_nxt = (rp_r == LAST_IDX) ? '0 : rp_r + AW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_rec;
  end

endmodule

>>> hdl/b64d_back.sv
module b64d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b64d_pkg::rec_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,  // [7:0] out_byte
  output logic           out_tlast,  // final_byte
  output logic           out_tuser   // decode_error
);
  import b64d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       at_end;

  assign at_end     = (idx_r == head.cnt - 2'd1);
  assign out_tvalid = head_valid;
  assign out_tlast  = head.fin && at_end;
  assign out_tuser  = head.err;
  assign pop        = out_tvalid && out_tready && at_end;

  always_comb begin
    case (idx_r)
      2'd0:    out_tdata = head.b0;
      2'd1:    out_tdata = head.b1;
      default: out_tdata = head.b2;
    endcase
    idx_nxt = idx_r;
    if (out_tvalid && out_tready) idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> hdl/base64_stream_decoder.sv
// Base64 stream decoder: one character beat per cycle enters on in_*, with
// in_tlast on the final character of a message. The front end decodes each
// group of four characters and writes one record (up to three bytes) into a
// QUEUE_DEPTH-entry queue; the back end sends one byte per cycle on out_*
// while a record is queued and out_tready is high. in_tready drops only
// while the queue is full. A malformed message ends with one beat with
// out_tuser set, out_tdata zero and out_tlast set; bytes already sent for
// that message are to be discarded.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // final_byte
  output logic       out_tuser   // decode_error
);
  import b64d_pkg::*;

  rec_t push_rec, head;
  logic push, pop, q_full, q_valid;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (q_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 8'd0)
    else $error("error beat not final or nonzero");

  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("queue full but no output beat");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("queue not empty after reset");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("record pushed into full queue");

endmodule

>>> sim/tb_base64_stream_decoder.sv
`timescale 1ns / 1ps

module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 38;
  localparam int SEXTET_PAD  = 64;
  localparam int SEXTET_BAD  = 65;

  class b64_scoreboard;
    typedef struct {
      logic [7:0] data;
      logic       fin;
      logic       err;
    } beat_t;

    bit [5:0] sextets [3];
    bit [1:0] pos;
    bit [2:0] pads;
    bit       failed;
    beat_t    expected_q [$];
    int       errors;
    int       bytes_ok;
    int       error_beats;

    function void clear_group();
      sextets[0] = '0;
      sextets[1] = '0;
      sextets[2] = '0;
      pos  = '0;
      pads = '0;
    endfunction

    function int sextet_value(bit [7:0] ch);
      if (ch >= "A" && ch <= "Z") return ch - "A";
      if (ch >= "a" && ch <= "z") return ch - "a" + 26;
      if (ch >= "0" && ch <= "9") return ch - "0" + 52;
      if (ch == PLUS_CHAR) return 62;
      if (ch == SLASH_CHAR) return 63;
      if (ch == PAD_CHAR) return SEXTET_PAD;
      return SEXTET_BAD;
    endfunction

    function void push_beat(bit [7:0] d, bit fin, bit err);
      beat_t b;
      b.data = d;
      b.fin  = fin;
      b.err  = err;
      expected_q.push_back(b);
    endfunction

    function void push_group(bit [5:0] tail, bit fin);
      bit [7:0] b0, b1, b2;
      int n;
      b0 = {sextets[0], sextets[1][5:4]};
      b1 = {sextets[1][3:0], sextets[2][5:2]};
      b2 = {sextets[2][1:0], tail};
      n  = (pads >= 2) ? 1 : (pads == 1) ? 2 : 3;
      push_beat(b0, (n == 1) ? fin : 1'b0, 1'b0);
      if (n >= 2) push_beat(b1, (n == 2) ? fin : 1'b0, 1'b0);
      if (n >= 3) push_beat(b2, fin, 1'b0);
    endfunction

    function void note_char(bit [7:0] ch, bit eot);
      int v;
      if (!failed) begin
        v = sextet_value(ch);
        if (v == SEXTET_BAD) begin
          failed = 1'b1;
        end else begin
          if (v == SEXTET_PAD) begin
            v = 0;
            if (pads < 7) pads++;
          end
          if (pos == LAST_POS) begin
            push_group(6'(v), eot);
            clear_group();
          end else begin
            sextets[pos] = 6'(v);
            pos++;
            if (eot) begin
              if (pads == 0) failed = 1'b1;
              else push_group(6'd0, 1'b1);
            end
          end
        end
      end
      if (eot) begin
        if (failed) push_beat(8'h00, 1'b1, 1'b1);
        clear_group();
        failed = 1'b0;
      end
    endfunction

    function void check_beat(bit [7:0] d, bit fin, bit err);
      beat_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat data=%h last=%b err=%b", $time, d, fin, err);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d !== e.data || fin !== e.fin || err !== e.err) begin
        $display("%0t: mismatch expected data=%h last=%b err=%b actual data=%h last=%b err=%b",
                 $time, e.data, e.fin, e.err, d, fin, err);
        errors++;
      end else if (err) begin
        error_beats++;
      end else begin
        bytes_ok++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  b64_scoreboard sb = new();
  bit  in_idle  = 1'b1;
  bit  out_idle = 1'b1;
  int  cycles   = 0;
  int  chars_sent = 0;
  int  msgs_sent  = 0;
  logic [7:0] msg_q [$];

  base64_stream_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending());
      $display("tb_base64_stream_decoder: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast, out_tuser);
  end

  always @(posedge clk) begin
    out_tready <= rst_n && (!out_idle || $urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_char(input logic [7:0] ch, input bit eot);
    while (in_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    if (eot) msgs_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) send_char(msg_q[i], i == msg_q.size() - 1);
  endtask

  function automatic logic [7:0] rand_b64_char();
    int k;
    k = $urandom_range(0, 63);
    if (k < 26) return 8'("A" + k);
    if (k < 52) return 8'("a" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    if (k == 62) return PLUS_CHAR;
    return SLASH_CHAR;
  endfunction

  // builds one random message; mostly well-formed, some broken or noisy
  task automatic build_msg();
    int kind, ngroups, len, npad;
    msg_q.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      ngroups = $urandom_range(1, 4);
      for (int i = 0; i < 4 * ngroups; i++) msg_q.push_back(rand_b64_char());
      npad = $urandom_range(0, 2);
      if (kind == 6) begin
        // short tail group closed by padding
        len = $urandom_range(1, 3);
        repeat (4 - len) void'(msg_q.pop_back());
        msg_q[msg_q.size() - 1] = PAD_CHAR;
      end else begin
        for (int i = 0; i < npad; i++) msg_q[msg_q.size() - 1 - i] = PAD_CHAR;
      end
      if (kind == 7) msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind == 8) begin
      len = $urandom_range(1, 11);
      if (len % 4 == 0) len++;
      for (int i = 0; i < len; i++) msg_q.push_back(rand_b64_char());
    end else begin
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: msg_q.push_back(PAD_CHAR);
          1: msg_q.push_back(8'($urandom_range(0, 255)));
          default: msg_q.push_back(rand_b64_char());
        endcase
      end
    end
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("AZaz09+/");
    send_text("TWE=");
    send_text("TQ==");
    send_text("=A=");
    send_text("TW");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);

    n = 0;
    while (chars_sent < 140) begin
      if (n >= 10 && n < 18) begin
        in_idle  = 1'b0;
        out_idle = 1'b0;
      end else begin
        in_idle  = 1'b1;
        out_idle = 1'b1;
      end
      build_msg();
      send_msg();
      n++;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d characters in %0d messages", chars_sent, msgs_sent);
    $display("checked %0d decoded bytes and %0d error beats", sb.bytes_ok, sb.error_beats);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_base64_stream_decoder: PASS");
    end else begin
      $display("tb_base64_stream_decoder: FAIL");
    end
    $finish;
  end

endmodule
